@@ design/cspm_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the cover-scale pixel mapper
// no dependencies
package cspm_pkg;

    localparam int COORD_BITS_DEF      = 12;
    localparam int BYTES_PER_PIXEL_DEF = 4;
    localparam int OFF_BITS            = 26;
    localparam int CFG_IDX_BITS        = 2;

    // register reset values
    localparam int VIEW_W_RST = 640;
    localparam int VIEW_H_RST = 480;
    localparam int SRC_W_RST  = 640;
    localparam int SRC_H_RST  = 480;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_W = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_H = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_W  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_H  = 2'd3;

    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_MUL,
        CFG_DIV,
        CFG_FIN
    } cfg_state_t;

endpackage

@@ design/cover_scale_pixel_mapper_core.sv @@
`timescale 1ns / 1ps
// cover-scale pixel mapper: maps a destination coordinate to its source pixel
// depends on cspm_pkg
//
// usage: items of dest_x/dest_y enter on the s_ channel, one mapped result per
// item leaves on the m_ channel; m_tuser carries map_valid.
// the four size registers are written through cfg_we/cfg_index/cfg_wdata.
// after reset and after every register write a sequential unit works out the
// scaled size and crop offsets: a multiply step, then a bit-serial divide that
// forms the scaled size, then a final step that stores the sizes and offsets;
// s_tready stays low until that final step is done.
// per item: COORD_BITS+6 register stages; m_tvalid is the valid bit of the last
// one;
// the divide per axis is a restoring divider with one quotient bit per stage.
// throughput: one item per cycle; each stage carries a valid bit and advances
// when its successor is empty or moving, so bubbles close up under a stall
// and new items are taken while a finished result waits on m_tready.
// reset clears all valid bits and restores the default 640x480 sizes.
module cover_scale_pixel_mapper_core #(
    parameter int COORD_BITS      = cspm_pkg::COORD_BITS_DEF,
    parameter int BYTES_PER_PIXEL = cspm_pkg::BYTES_PER_PIXEL_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [cspm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // dest_x, dest_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // src_x, src_y, src_byte_offset
    output logic [((2*COORD_BITS+cspm_pkg::OFF_BITS+7)/8)*8-1:0] m_tdata,
    // map_valid
    output logic                                  m_tuser
);
    import cspm_pkg::*;

    localparam int P     = COORD_BITS;
    localparam int NW    = 3 * P;
    localparam int NS    = P + 6;
    localparam int CW    = $clog2(2 * P);
    localparam int OUT_W = ((2 * P + OFF_BITS + 7) / 8) * 8;
    localparam int ST_D0 = 2;
    localparam int ST_C  = P + 3;
    localparam int ST_M  = P + 4;
    localparam int ST_O  = P + 5;

    // ---------------- configuration ----------------
    logic [P-1:0] vw_reg, vh_reg, sw_reg, sh_reg;
    logic         any_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw_reg <= P'(VIEW_W_RST);
            vh_reg <= P'(VIEW_H_RST);
            sw_reg <= P'(SRC_W_RST);
            sh_reg <= P'(SRC_H_RST);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VIEW_W: vw_reg <= cfg_wdata;
                REG_VIEW_H: vh_reg <= cfg_wdata;
                REG_SRC_W:  sw_reg <= cfg_wdata;
                REG_SRC_H:  sh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign any_zero = (vw_reg == '0) || (vh_reg == '0) || (sw_reg == '0) || (sh_reg == '0);

    cfg_state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg;
    logic [2*P-1:0] dnum_reg;
    logic [P:0]     drem_reg;
    logic [P-1:0]   ddiv_reg;
    logic           keep_w_reg;
    logic [2*P-1:0] scw_reg, sch_reg, oxo_reg, oyo_reg;
    logic           do_load, do_step, do_fin, div_last;

    assign div_last = (cnt_reg == CW'(2 * P - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CFG_IDLE: state_next = CFG_IDLE;
            CFG_MUL:  state_next = CFG_DIV;
            CFG_DIV:  state_next = div_last ? CFG_FIN : CFG_DIV;
            CFG_FIN:  state_next = CFG_IDLE;
            default:  state_next = CFG_IDLE;
        endcase
        if (cfg_we) begin
            state_next = CFG_MUL;
        end
    end

    always_comb begin
        do_load = 1'b0;
        do_step = 1'b0;
        do_fin  = 1'b0;
        case (state_reg)
            CFG_MUL: do_load = 1'b1;
            CFG_DIV: do_step = 1'b1;
            CFG_FIN: do_fin  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CFG_MUL;
        end else begin
            state_reg <= state_next;
        end
    end

    logic [2*P-1:0] prod_w, prod_h;
    logic [P:0]     rem_sh;
    logic           rem_ge;
    logic [2*P-1:0] sc_w_new, sc_h_new;

    assign prod_w = (2*P)'(vw_reg) * (2*P)'(sh_reg);
    assign prod_h = (2*P)'(vh_reg) * (2*P)'(sw_reg);
    assign rem_sh = {drem_reg[P-1:0], dnum_reg[2*P-1]};
    assign rem_ge = rem_sh >= {1'b0, ddiv_reg};
    assign sc_w_new = keep_w_reg ? (2*P)'(vw_reg) : dnum_reg;
    assign sc_h_new = keep_w_reg ? dnum_reg : (2*P)'(vh_reg);

    always_ff @(posedge aclk) begin
        if (do_load) begin
            keep_w_reg <= prod_w >= prod_h;
            // the kept axis divides the cross product by its source size
            dnum_reg   <= (prod_w >= prod_h) ? prod_w : prod_h;
            ddiv_reg   <= (prod_w >= prod_h) ? sw_reg : sh_reg;
            drem_reg   <= '0;
            cnt_reg    <= '0;
        end
        if (do_step) begin
            drem_reg <= rem_ge ? (rem_sh - {1'b0, ddiv_reg}) : rem_sh;
            dnum_reg <= {dnum_reg[2*P-2:0], rem_ge};
            cnt_reg  <= cnt_reg + CW'(1);
        end
        if (do_fin) begin
            scw_reg <= sc_w_new;
            sch_reg <= sc_h_new;
            oxo_reg <= (sc_w_new >= (2*P)'(vw_reg)) ? ((sc_w_new - (2*P)'(vw_reg)) >> 1) : '0;
            oyo_reg <= (sc_h_new >= (2*P)'(vh_reg)) ? ((sc_h_new - (2*P)'(vh_reg)) >> 1) : '0;
        end
    end

    // ---------------- item pipeline ----------------
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   rdy;
    logic          acc;

    always_comb begin
        rdy[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0] && (state_reg == CFG_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
                vld_next[i] = (i == 0) ? acc : vld_reg[(i == 0) ? 0 : i - 1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    logic [P-1:0] dx, dy;
    assign dx = s_tdata[P-1:0];
    assign dy = s_tdata[2*P-1:P];

    // stage 0: range check and crop offset
    logic           inv0_reg;
    logic [2*P-1:0] ax0_reg, ay0_reg;
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            inv0_reg <= !any_zero && (dx < vw_reg) && (dy < vh_reg);
            ax0_reg  <= (2*P)'(dx) + oxo_reg;
            ay0_reg  <= (2*P)'(dy) + oyo_reg;
        end
    end

    // stage 1: numerators
    logic          inv1_reg;
    logic [NW-1:0] nx1_reg, ny1_reg;
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            inv1_reg <= inv0_reg;
            nx1_reg  <= NW'(ax0_reg) * NW'(sw_reg);
            ny1_reg  <= NW'(ay0_reg) * NW'(sh_reg);
        end
    end

    // divider stages: the first flags a quotient too wide to need, then one bit each
    logic          invd_reg [P+1];
    logic [NW-1:0] rx_reg [P+1], ry_reg [P+1];
    logic [P-1:0]  qx_reg [P+1], qy_reg [P+1];
    logic          ovx_reg [P+1], ovy_reg [P+1];

    always_ff @(posedge aclk) begin
        if (rdy[ST_D0]) begin
            invd_reg[0] <= inv1_reg;
            rx_reg[0]   <= nx1_reg;
            ry_reg[0]   <= ny1_reg;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ovx_reg[0]  <= nx1_reg >= (NW'(scw_reg) << P);
            ovy_reg[0]  <= ny1_reg >= (NW'(sch_reg) << P);
        end
    end

    for (genvar j = 1; j <= P; j++) begin : g_div
        localparam int B = P - j;
        logic [NW-1:0] dvx, dvy;
        logic          gex, gey;
        assign dvx = NW'(scw_reg) << B;
        assign dvy = NW'(sch_reg) << B;
        assign gex = rx_reg[j-1] >= dvx;
        assign gey = ry_reg[j-1] >= dvy;
        always_ff @(posedge aclk) begin
            if (rdy[ST_D0+j]) begin
                invd_reg[j] <= invd_reg[j-1];
                ovx_reg[j]  <= ovx_reg[j-1];
                ovy_reg[j]  <= ovy_reg[j-1];
                rx_reg[j]   <= gex ? (rx_reg[j-1] - dvx) : rx_reg[j-1];
                ry_reg[j]   <= gey ? (ry_reg[j-1] - dvy) : ry_reg[j-1];
                qx_reg[j]   <= qx_reg[j-1] | (gex ? (P'(1) << B) : '0);
                qy_reg[j]   <= qy_reg[j-1] | (gey ? (P'(1) << B) : '0);
            end
        end
    end

    // clamp to the source range, zero when out of view
    logic         invc_reg;
    logic [P-1:0] sxc_reg, syc_reg;
    logic [P-1:0] swm1, shm1;
    assign swm1 = sw_reg - P'(1);
    assign shm1 = sh_reg - P'(1);
    always_ff @(posedge aclk) begin
        if (rdy[ST_C]) begin
            invc_reg <= invd_reg[P];
            if (!invd_reg[P]) begin
                sxc_reg <= '0;
                syc_reg <= '0;
            end else begin
                sxc_reg <= (ovx_reg[P] || qx_reg[P] > swm1) ? swm1 : qx_reg[P];
                syc_reg <= (ovy_reg[P] || qy_reg[P] > shm1) ? shm1 : qy_reg[P];
            end
        end
    end

    // row base
    logic           invm_reg;
    logic [P-1:0]   sxm_reg, sym_reg;
    logic [2*P-1:0] rowm_reg;
    always_ff @(posedge aclk) begin
        if (rdy[ST_M]) begin
            invm_reg <= invc_reg;
            sxm_reg  <= sxc_reg;
            sym_reg  <= syc_reg;
            rowm_reg <= (2*P)'(syc_reg) * (2*P)'(sw_reg);
        end
    end

    // byte offset, output register
    logic                invo_reg;
    logic [P-1:0]        sxo_reg, syo_reg;
    logic [OFF_BITS-1:0] offo_reg;
    logic [2*P:0]        pix_idx;
    assign pix_idx = (2*P+1)'(rowm_reg) + (2*P+1)'(sxm_reg);
    always_ff @(posedge aclk) begin
        if (rdy[ST_O]) begin
            invo_reg <= invm_reg;
            sxo_reg  <= sxm_reg;
            syo_reg  <= sym_reg;
            offo_reg <= OFF_BITS'(pix_idx * BYTES_PER_PIXEL);
        end
    end

    assign m_tvalid = vld_reg[ST_O];
    assign m_tuser  = invo_reg;
    assign m_tdata  = OUT_W'({offo_reg, syo_reg, sxo_reg});

    // ---------------- checks ----------------
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == CFG_IDLE))
        else $error("item taken while sizes are recomputed");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("unmapped item carries nonzero fields");

    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (sxo_reg < sw_reg) && (syo_reg < sh_reg))
        else $error("source coordinate past the frame");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for cover_scale_pixel_mapper_core: random and directed coordinates
// under several size settings, checked against an in-bench cover-scale predictor
// depends on cspm_pkg and the mapper core
module testbench;
    import cspm_pkg::*;

    localparam int CB        = COORD_BITS_DEF;
    localparam int TD_W      = ((2*CB+7)/8)*8;
    localparam int MD_W      = ((2*CB+OFF_BITS+7)/8)*8;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [CB-1:0] dx;
        logic [CB-1:0] dy;
    } coord_t;

    typedef struct packed {
        logic                ok;
        logic [CB-1:0]       sx;
        logic [CB-1:0]       sy;
        logic [OFF_BITS-1:0] off;
    } mapping_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_we = 1'b0;
    logic [1:0]      cfg_index = REG_VIEW_W;
    logic [CB-1:0]   cfg_wdata = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [TD_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [MD_W-1:0] m_tdata;
    logic            m_tuser;

    cover_scale_pixel_mapper_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // bench copy of the size registers
    logic [CB-1:0] view_w = CB'(VIEW_W_RST), view_h = CB'(VIEW_H_RST);
    logic [CB-1:0] src_w = CB'(SRC_W_RST), src_h = CB'(SRC_H_RST);

    coord_t   pending_coords[$];
    mapping_t expected_maps[$];
    coord_t   in_flight;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_left = 0;
    int       errors = 0;
    int       cycles = 0;

    initial forever #5 aclk = ~aclk;

    function automatic longint unsigned axis_map(longint unsigned d, longint unsigned ofs,
                                                 longint unsigned src, longint unsigned scl);
        longint unsigned s;
        if (scl == 0) return 0;
        s = ((d + ofs) * src) / scl;
        if (s > src - 1) s = src - 1;
        return s;
    endfunction

    function automatic mapping_t map_coord(coord_t c);
        mapping_t r;
        longint unsigned vw, vh, sw, sh, scl_w, scl_h, ox, oy, sx, sy;
        r = '0;
        vw = view_w; vh = view_h; sw = src_w; sh = src_h;
        if (vw == 0 || vh == 0 || sw == 0 || sh == 0) return r;
        if (c.dx >= vw || c.dy >= vh) return r;
        if (vw * sh >= vh * sw) begin
            scl_w = vw;
            scl_h = (sh * vw) / sw;
        end else begin
            scl_h = vh;
            scl_w = (sw * vh) / sh;
        end
        ox = (scl_w >= vw) ? (scl_w - vw) / 2 : 0;
        oy = (scl_h >= vh) ? (scl_h - vh) / 2 : 0;
        sx = axis_map(c.dx, ox, sw, scl_w);
        sy = axis_map(c.dy, oy, sh, scl_h);
        r.ok  = 1'b1;
        r.sx  = sx[CB-1:0];
        r.sy  = sy[CB-1:0];
        r.off = OFF_BITS'((sy * sw + sx) * BYTES_PER_PIXEL_DEF);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: holds an item until taken, then offers the next one
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_maps.push_back(map_coord(in_flight));
            if (!s_tvalid || s_tready) begin
                if (pending_coords.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_flight = pending_coords.pop_front();
                    s_tdata  <= TD_W'({in_flight.dy, in_flight.dx});
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge aclk) begin
        mapping_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_maps.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = expected_maps.pop_front();
                if (m_tuser !== want.ok) report_mismatch("map_valid", m_tuser, want.ok);
                if (m_tdata[CB-1:0] !== want.sx) report_mismatch("src_x", m_tdata[CB-1:0], want.sx);
                if (m_tdata[2*CB-1:CB] !== want.sy)
                    report_mismatch("src_y", m_tdata[2*CB-1:CB], want.sy);
                if (m_tdata[2*CB+OFF_BITS-1:2*CB] !== want.off)
                    report_mismatch("src_byte_offset", m_tdata[2*CB+OFF_BITS-1:2*CB], want.off);
            end
        end
        m_tready <= (hold_left > 0) ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [CB-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_VIEW_W: view_w = val;
            REG_VIEW_H: view_h = val;
            REG_SRC_W:  src_w = val;
            default:    src_h = val;
        endcase
    endtask

    task automatic set_sizes(int vw, int vh, int sw, int sh);
        write_reg(REG_VIEW_W, CB'(vw));
        write_reg(REG_VIEW_H, CB'(vh));
        write_reg(REG_SRC_W, CB'(sw));
        write_reg(REG_SRC_H, CB'(sh));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // checked away from the rising edge so the driver's updates have settled
    task automatic drain();
        while (pending_coords.size() != 0 || expected_maps.size() != 0 || s_tvalid)
            @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic add_coord(int x, int y);
        coord_t c;
        c.dx = CB'(x);
        c.dy = CB'(y);
        pending_coords.push_back(c);
    endtask

    // mostly in-view coordinates, some anywhere in the field range
    task automatic add_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 25 || view_w == 0 || view_h == 0)
                add_coord($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                add_coord($urandom_range(0, view_w - 1), $urandom_range(0, view_h - 1));
        end
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners and edges of the default view
        add_coord(0, 0);       add_coord(639, 479);   add_coord(640, 0);
        add_coord(0, 480);     add_coord(4095, 4095); add_coord(4095, 0);
        add_coord(0, 4095);    add_coord(320, 240);   add_coord(639, 0);
        add_coord(0, 479);     add_coord(2730, 1365); add_coord(1365, 2730);
        drain();

        // wide source, tiny source, huge source and zero sizes
        set_sizes(640, 480, 1920, 1080);
        add_coord(0, 0); add_coord(639, 479); add_coord(320, 240);
        drain();
        set_sizes(4095, 4095, 1, 1);
        add_coord(0, 0); add_coord(4094, 4094); add_coord(4095, 4095);
        drain();
        set_sizes(1, 1, 4095, 4095);
        add_coord(0, 0); add_coord(1, 0); add_coord(0, 1);
        drain();
        set_sizes(0, 480, 640, 480);
        add_coord(0, 0); add_coord(5, 5);
        drain();
        set_sizes(640, 480, 640, 0);
        add_coord(0, 0); add_coord(5, 5);
        drain();

        // long receiver hold-off while the sender keeps offering
        set_sizes(800, 600, 1280, 720);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_left <= 300;
        add_random(80);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_sizes(4095, 1, 1, 4095);
                1: set_sizes(1, 4095, 4095, 1);
                2: set_sizes(4095, 4095, 4095, 4095);
                3: set_sizes(0, 0, 0, 0);
                default: set_sizes($urandom_range(1, 4095), $urandom_range(1, 4095),
                                   $urandom_range(1, 4095), $urandom_range(1, 4095));
            endcase
            set_idling(ph);
            add_random(55);
            drain();
        end

        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
